// ----- rtl/core/argb_color_crossfade_assert.svh -----
// Assertion macros shared by the crossfade RTL.
`ifndef ARGB_COLOR_CROSSFADE_ASSERT_SVH
`define ARGB_COLOR_CROSSFADE_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define ACF_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("crossfade check failed");
// Clocked check that also holds during reset.
`define ACF_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("crossfade check failed");
`else
`define ACF_ASSERT(label, prop)
`define ACF_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- rtl/core/acf_pkg.sv -----
// Shared constants and types for the ARGB colour crossfade block.
`default_nettype none

package acf_pkg;

    localparam int FracBits = 16;
    localparam int FracW    = 18;
    localparam int FracOutW = FracBits + 1;
    localparam int ColorW   = 32;
    localparam int LenW     = 16;
    localparam int FrameW   = 10;
    localparam int ThrW     = 10;
    localparam int AccW     = 11;
    localparam int FuncW    = 2;
    localparam int ChanW    = 8;

    localparam int DivW     = AccW + FracBits;
    localparam int DivCntW  = $clog2(DivW + 1);
    localparam int SumW     = DivW + 1;
    localparam int ProdW    = ChanW + FracOutW;

    localparam logic [FracW-1:0] FracOne  = FracW'(1) << FracBits;
    localparam logic [FracW-1:0] FracMax  = '1;
    localparam logic [ThrW-1:0]  ThrReset = ThrW'(100);
    localparam logic [ColorW-1:0] ColorReset = '1;

    // Input stream packing, lowest field first.
    localparam int InColorLo = 0;
    localparam int InDurLo   = InColorLo + ColorW;
    localparam int InFrameLo = InDurLo + LenW;
    localparam int InFracLo  = InFrameLo + FrameW;
    localparam int InFieldsW = InFracLo + FracOutW;
    localparam int IN_TDATA_W = ((InFieldsW + 7) / 8) * 8;
    localparam int IN_TUSER_W = FuncW;

    // Output stream packing, lowest field first.
    localparam int OutFracLo  = ColorW;
    localparam int OutFieldsW = OutFracLo + FracOutW;
    localparam int OUT_TDATA_W = ((OutFieldsW + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 1;

    typedef logic [FuncW-1:0]  func_t;
    typedef logic [ColorW-1:0] color_t;
    typedef logic [FracW-1:0]  frac_t;

    localparam func_t FUNC_START    = 2'd0;
    localparam func_t FUNC_TICK     = 2'd1;
    localparam func_t FUNC_SET_FRAC = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/core/argb_color_crossfade.sv -----
// Top level of the ARGB colour crossfade: sequencer, shared divider and blend multiplier.
//
//  Channel   | Direction | Handshake         | Contents
//  ----------+-----------+-------------------+------------------------------------------
//  s_        | in        | s_tvalid/s_tready | request: func, colour, length, frame, fraction
//  m_        | out       | m_tvalid/m_tready | result: colour, fading flag, fraction
//  cfg_wr_   | in        | cfg_wr_en         | accumulate threshold in ms
//
// A start, set-fraction or unused request, and a tick while no fade runs, go from accept
// straight to hand-over. A tick that does not pass the threshold runs four blend steps
// through the one channel multiplier between accept and hand-over. A tick that passes
// the threshold first runs the restoring divider, one quotient bit per cycle over 27
// bits, then one step to add and saturate, and blends only if progress stays within one.
// Reset is synchronous and active low; all colours come up white and no fade runs.
// A result is held in the output register until taken, and the next request is
// accepted meanwhile; the block stalls in its final step only if that register
// is still full.
`default_nettype none

module argb_color_crossfade (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration: accumulate threshold in ms.
    input  wire logic                              cfg_wr_en,
    input  wire logic [acf_pkg::ThrW-1:0]          cfg_wr_data,
    // Requests. tdata from bit 0: color_in[31:0], duration_ms[47:32],
    // frame_ms[57:48], fraction_in[74:58], zero padding[79:75].
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [acf_pkg::IN_TDATA_W-1:0]    s_tdata,
    // tuser from bit 0: func[1:0].
    input  wire logic [acf_pkg::IN_TUSER_W-1:0]    s_tuser,
    // Results. tdata from bit 0: color_out[31:0], fraction_out[48:32],
    // zero padding[55:49].
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [acf_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // tuser from bit 0: fading.
    output logic [acf_pkg::OUT_TUSER_W-1:0]        m_tuser
);

    import acf_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a request
    localparam logic [2:0] ST_DIV   = 3'd1;  // one quotient bit per cycle
    localparam logic [2:0] ST_ADD   = 3'd2;  // add increment to progress, saturate
    localparam logic [2:0] ST_BLEND = 3'd3;  // one colour channel per cycle
    localparam logic [2:0] ST_DONE  = 3'd4;  // hand the result to the output register

    logic [2:0]          state_reg, state_next;
    color_t              cur_reg, cur_next;
    color_t              start_reg, start_next;
    color_t              tgt_reg, tgt_next;
    frac_t               frac_reg, frac_next;
    logic [LenW-1:0]     len_reg, len_next;
    logic [AccW-1:0]     acc_reg, acc_next;
    logic [ThrW-1:0]     thr_reg, thr_next;

    // Datapath scratch: dividend shifting out while the quotient shifts in.
    logic [DivW-1:0]     div_reg, div_next;
    logic [LenW-1:0]     rem_reg, rem_next;
    logic [DivCntW-1:0]  cnt_reg, cnt_next;
    logic [1:0]          ch_reg, ch_next;
    color_t              blend_reg, blend_next;

    logic                m_valid_reg, m_valid_next;
    color_t              out_color_reg, out_color_next;
    logic [FracOutW-1:0] out_frac_reg, out_frac_next;
    logic                out_fading_reg, out_fading_next;

    // Request fields.
    func_t               in_func;
    color_t              in_color;
    logic [LenW-1:0]     in_dur;
    logic [FrameW-1:0]   in_frame;
    logic [FracOutW-1:0] in_fin;
    logic                accept;

    assign in_func  = s_tuser[FuncW-1:0];
    assign in_color = s_tdata[InColorLo +: ColorW];
    assign in_dur   = s_tdata[InDurLo +: LenW];
    assign in_frame = s_tdata[InFrameLo +: FrameW];
    assign in_fin   = s_tdata[InFracLo +: FracOutW];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Accumulator add with saturation at its full-scale value.
    logic [AccW:0]   acc_sum;
    logic [AccW-1:0] acc_sat;
    logic            acc_over;

    assign acc_sum  = {1'b0, acc_reg} + (AccW + 1)'(in_frame);
    assign acc_sat  = acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
    assign acc_over = acc_sat > AccW'(thr_reg);

    // Restoring divider step, shared across all division cycles.
    logic [LenW:0] rem_shift;
    logic [LenW:0] rem_diff;
    logic          rem_ge;

    assign rem_shift = {rem_reg, div_reg[DivW-1]};
    assign rem_diff  = rem_shift - {1'b0, len_reg};
    assign rem_ge    = rem_shift >= {1'b0, len_reg};

    // Progress sum with saturation to the progress register's range.
    logic [SumW-1:0] frac_sum;
    frac_t           frac_sat;

    assign frac_sum = SumW'(frac_reg) + SumW'(div_reg);
    assign frac_sat = (frac_sum > SumW'(FracMax)) ? FracMax : frac_sum[FracW-1:0];

    // Blend unit: one channel per cycle through a single multiplier.
    logic [ChanW-1:0] ch_a, ch_b, ch_diff, ch_step, ch_val;
    logic             ch_up;
    logic [ProdW-1:0] ch_prod;

    assign ch_a    = start_reg[{ch_reg, 3'b000} +: ChanW];
    assign ch_b    = tgt_reg[{ch_reg, 3'b000} +: ChanW];
    assign ch_up   = ch_b >= ch_a;
    assign ch_diff = ch_up ? (ch_b - ch_a) : (ch_a - ch_b);
    assign ch_prod = ProdW'(ch_diff) * ProdW'(frac_reg[FracOutW-1:0]);
    assign ch_step = ch_prod[FracBits +: ChanW];
    assign ch_val  = ch_up ? (ch_a + ch_step) : (ch_a - ch_step);

    // Reported progress, clamped to one.
    logic [FracOutW-1:0] frac_report;
    assign frac_report = (frac_reg > FracOne) ? FracOne[FracOutW-1:0]
                                              : frac_reg[FracOutW-1:0];

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        start_next      = start_reg;
        tgt_next        = tgt_reg;
        frac_next       = frac_reg;
        len_next        = len_reg;
        acc_next        = acc_reg;
        thr_next        = cfg_wr_en ? cfg_wr_data : thr_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        ch_next         = ch_reg;
        blend_next      = blend_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_color_next  = out_color_reg;
        out_frac_next   = out_frac_reg;
        out_fading_next = out_fading_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DONE;
                    case (in_func)
                        FUNC_START: begin
                            if (in_color == cur_reg || in_dur == '0) begin
                                // Nothing to fade: jump straight to the new colour.
                                cur_next   = in_color;
                                start_next = in_color;
                                tgt_next   = in_color;
                                len_next   = '0;
                                frac_next  = '0;
                                acc_next   = '0;
                            end else begin
                                // A fade under way restarts from the colour shown now.
                                start_next = cur_reg;
                                tgt_next   = in_color;
                                frac_next  = '0;
                                len_next   = in_dur;
                            end
                        end
                        FUNC_TICK: begin
                            if (len_reg != '0) begin
                                acc_next = acc_sat;
                                if (acc_over) begin
                                    div_next   = {acc_sat, FracBits'(0)};
                                    rem_next   = '0;
                                    cnt_next   = DivCntW'(DivW);
                                    state_next = ST_DIV;
                                end else begin
                                    ch_next    = '0;
                                    state_next = ST_BLEND;
                                end
                            end
                        end
                        FUNC_SET_FRAC: begin
                            if (FracW'(in_fin) == FracOne) begin
                                start_next = tgt_reg;
                                cur_next   = tgt_reg;
                                frac_next  = '0;
                                len_next   = '0;
                            end else if (FracW'(in_fin) < FracOne) begin
                                frac_next = FracW'(in_fin);
                                acc_next  = '0;
                            end
                        end
                        default: begin
                            // Unused code: report the status unchanged.
                        end
                    endcase
                end
            end
            ST_DIV: begin
                rem_next = rem_ge ? rem_diff[LenW-1:0] : rem_shift[LenW-1:0];
                div_next = {div_reg[DivW-2:0], rem_ge};
                cnt_next = cnt_reg - DivCntW'(1);
                if (cnt_reg == DivCntW'(1)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                acc_next = '0;
                if (frac_sat > FracOne) begin
                    // Progress ran past one: settle on the target.
                    start_next = tgt_reg;
                    cur_next   = tgt_reg;
                    frac_next  = '0;
                    len_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    frac_next  = frac_sat;
                    ch_next    = '0;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                blend_next = {ch_val, blend_reg[ColorW-1:ChanW]};
                ch_next    = ch_reg + 2'd1;
                if (ch_reg == 2'd3) begin
                    cur_next   = {ch_val, blend_reg[ColorW-1:ChanW]};
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    out_color_next  = cur_reg;
                    out_frac_next   = frac_report;
                    out_fading_next = (len_reg != '0);
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_reg     <= ColorReset;
            start_reg   <= ColorReset;
            tgt_reg     <= ColorReset;
            frac_reg    <= '0;
            len_reg     <= '0;
            acc_reg     <= '0;
            thr_reg     <= ThrReset;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            start_reg   <= start_next;
            tgt_reg     <= tgt_next;
            frac_reg    <= frac_next;
            len_reg     <= len_next;
            acc_reg     <= acc_next;
            thr_reg     <= thr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath scratch and output payload.
    always_ff @(posedge aclk) begin
        div_reg        <= div_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        ch_reg         <= ch_next;
        blend_reg      <= blend_next;
        out_color_reg  <= out_color_next;
        out_frac_reg   <= out_frac_next;
        out_fading_reg <= out_fading_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_frac_reg, out_color_reg});
    assign m_tuser  = out_fading_reg;

    `include "argb_color_crossfade_assert.svh"

    // A settled block shows its target and has nothing left between start and target.
    `ACF_ASSERT(a_idle_settled,
        (state_reg == ST_IDLE && len_reg == '0) |-> (cur_reg == tgt_reg && start_reg == tgt_reg))
    // Stored progress never exceeds one between requests, nor while blending.
    `ACF_ASSERT(a_frac_bounded,
        (state_reg == ST_IDLE || state_reg == ST_BLEND) |-> (frac_reg <= FracOne))
    // An accepted request always holds the input side off in the next cycle.
    `ACF_ASSERT(a_busy_after_accept, accept |=> !s_tready)
    // The divider only runs with a nonzero divisor and a live bit count.
    `ACF_ASSERT(a_div_sane,
        (state_reg == ST_DIV) |-> (len_reg != '0 && cnt_reg != '0))

endmodule

`default_nettype wire
